// File: rtl/lz_frame_delta_decompressor_defines.svh
`ifndef LZ_FRAME_DELTA_DECOMPRESSOR_DEFINES_SVH
`define LZ_FRAME_DELTA_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LZFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LZFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lzfd_pkg.sv
`timescale 1ns / 1ps

package lzfd_pkg;

  localparam int unsigned PreambleBytes = 4096;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_IMAGE_PIXELS = 2'd0,
    CFG_FRAME_SKIP   = 2'd1,
    CFG_DECODE_MODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_TWO   = 2'd0,
    MODE_FIVE  = 2'd1,
    MODE_SIX   = 2'd2,
    MODE_EIGHT = 2'd3
  } mode_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// File: rtl/lzfd_store.sv
`timescale 1ns / 1ps

module lzfd_store #(
  parameter int unsigned Depth = 69632,
  parameter int unsigned AddrW = 17
) (
  input  logic             clk_i,
  input  lzfd_pkg::mem_ctl_t ctl_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);
  import lzfd_pkg::*;

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/lzfd_ctrl.sv
`timescale 1ns / 1ps

module lzfd_ctrl #(
  parameter int unsigned IMAGE_BYTES = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [16:0]                image_pixels_i,
  input  logic [23:0]                frame_skip_i,
  input  logic [1:0]                 decode_mode_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 func_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [15:0]                read_address_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 read_value_o,
  output logic                       frame_done_o,
  output logic [16:0]                write_count_o,
  output lzfd_pkg::mem_ctl_t         mem_ctl_o,
  output logic [$clog2(lzfd_pkg::PreambleBytes + IMAGE_BYTES)-1:0] mem_waddr_o,
  output logic [7:0]                 mem_wdata_o,
  output logic [$clog2(lzfd_pkg::PreambleBytes + IMAGE_BYTES)-1:0] mem_raddr_o,
  input  logic [7:0]                 mem_rdata_i
);
  import lzfd_pkg::*;

  localparam int unsigned StoreBytes = PreambleBytes + IMAGE_BYTES;
  localparam int unsigned AW = $clog2(StoreBytes);
  localparam int unsigned PW = $clog2(IMAGE_BYTES + 1);
  localparam int unsigned TW = ((PW > 17) ? PW : 17) + 1;
  localparam int unsigned SW = AW + 1;

  localparam logic [3:0] SQ_CLEAR  = 4'd0;
  localparam logic [3:0] SQ_IDLE   = 4'd1;
  localparam logic [3:0] SQ_RDWAIT = 4'd2;
  localparam logic [3:0] SQ_PRE    = 4'd3;
  localparam logic [3:0] SQ_FEED   = 4'd4;
  localparam logic [3:0] SQ_ADV    = 4'd5;
  localparam logic [3:0] SQ_CPRD   = 4'd6;
  localparam logic [3:0] SQ_CPWR   = 4'd7;
  localparam logic [3:0] SQ_PF1    = 4'd8;
  localparam logic [3:0] SQ_PF2    = 4'd9;
  localparam logic [3:0] SQ_PF3    = 4'd10;
  localparam logic [3:0] SQ_PFW    = 4'd11;
  localparam logic [3:0] SQ_RESP   = 4'd12;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_DONE    = 5'd1;
  localparam logic [4:0] PH_TOP     = 5'd2;
  localparam logic [4:0] PH_TAGBYTE = 5'd3;
  localparam logic [4:0] PH_LIT     = 5'd4;
  localparam logic [4:0] PH_NEAR_A  = 5'd5;
  localparam logic [4:0] PH_NEAR_B  = 5'd6;
  localparam logic [4:0] PH_SKIP2   = 5'd7;
  localparam logic [4:0] PH_SKIP5   = 5'd8;
  localparam logic [4:0] PH_SKIPLO  = 5'd9;
  localparam logic [4:0] PH_SKIPHI  = 5'd10;
  localparam logic [4:0] PH_SHORT5  = 5'd11;
  localparam logic [4:0] PH_T0      = 5'd12;
  localparam logic [4:0] PH_RUNBITS = 5'd13;
  localparam logic [4:0] PH_RUNLIT  = 5'd14;
  localparam logic [4:0] PH_T1      = 5'd15;
  localparam logic [4:0] PH_T1S     = 5'd16;
  localparam logic [4:0] PH_SKB     = 5'd17;
  localparam logic [4:0] PH_SKC     = 5'd18;
  localparam logic [4:0] PH_T2      = 5'd19;
  localparam logic [4:0] PH_T2O     = 5'd20;
  localparam logic [4:0] PH_T2B     = 5'd21;
  localparam logic [4:0] PH_NEAR8   = 5'd22;
  localparam logic [4:0] PH_FAR     = 5'd23;
  localparam logic [4:0] PH_FARLEN  = 5'd24;
  localparam logic [4:0] PH_FAROFF  = 5'd25;
  localparam logic [4:0] PH_FAR4    = 5'd26;
  localparam logic [4:0] PH_FWD4    = 5'd27;
  localparam logic [4:0] PH_FWDOFF  = 5'd28;

  logic [3:0]    sq_q, sq_d;
  logic [4:0]    ph_q, ph_d;
  logic [1:0]    mode_q, mode_d;
  logic [PW-1:0] limit_q, limit_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [31:0]   queue_q, queue_d;
  logic [5:0]    fill_q, fill_d;
  logic [2:0]    refill_q, refill_d;
  logic [4:0]    runb_q, runb_d;
  logic [1:0]    sub_q, sub_d;
  logic [16:0]   plen_q, plen_d;
  logic [11:0]   poff_q, poff_d;
  logic          done_q, done_d;
  logic [7:0]    byte_q, byte_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [11:0]   pre_q, pre_d;
  logic [SW-1:0] src_q, src_d;
  logic          src_ok_q, src_ok_d;
  logic [7:0]    c1_q, c1_d;
  logic [7:0]    c2_q, c2_d;
  logic          tog_q, tog_d;
  logic [7:0]    val_q, val_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_val_q, out_val_d;
  logic          out_done_q, out_done_d;
  logic [16:0]   out_cnt_q, out_cnt_d;

  logic          in_ready;
  logic          pos_room;
  logic [AW-1:0] put_addr;
  logic [SW-1:0] end_s;
  logic [SW-1:0] src_new;
  logic [SW-1:0] src_p1;
  logic [4:0]    tk_n;
  logic [31:0]   tk_mask;
  logic [31:0]   tk_val;
  logic [31:0]   tk_rest;
  logic          cp_start;
  logic [13:0]   cp_add;
  logic [16:0]   cp_len;
  logic [11:0]   offs;
  logic [16:0]   run_left;
  logic [PW-1:0] lim_new;
  logic [PW-1:0] skip_new;

  function automatic logic [PW-1:0] skip_to(input logic [PW-1:0] p, input logic [TW-1:0] n,
                                            input logic [PW-1:0] lim);
    logic [TW-1:0] t;
    t = TW'(p) + n;
    skip_to = (t > TW'(lim)) ? lim : PW'(t);
  endfunction

  assign pos_room = pos_q < limit_q;
  assign put_addr = AW'(PreambleBytes) + AW'(pos_q);
  assign end_s    = SW'(PreambleBytes) + SW'(limit_q);
  assign src_new  = SW'(pos_q) + SW'(cp_add);
  assign src_p1   = src_q + SW'(1);
  assign offs     = poff_q + 12'(byte_q);
  assign run_left = (plen_q != 17'd0) ? plen_q - 17'd1 : 17'd0;
  assign lim_new  = (32'(image_pixels_i) > IMAGE_BYTES) ? PW'(IMAGE_BYTES)
                                                        : PW'(image_pixels_i);
  assign skip_new = (32'(frame_skip_i) > 32'(lim_new)) ? lim_new : PW'(frame_skip_i);

  // Shared bit extractor for the wide methods.
  always_comb begin
    case (ph_q)
      PH_T0, PH_T1:                      tk_n = 5'd1;
      PH_TOP, PH_T2:                     tk_n = 5'd2;
      PH_T1S, PH_T2O, PH_FAR4, PH_FWD4:  tk_n = 5'd4;
      PH_RUNBITS:                        tk_n = runb_q + 5'd1;
      default:                           tk_n = 5'd0;
    endcase
  end

  assign tk_mask = ~(32'hFFFF_FFFF << tk_n);
  assign tk_val  = queue_q & tk_mask;
  assign tk_rest = queue_q >> tk_n;

  always_comb begin
    sq_d        = sq_q;
    ph_d        = ph_q;
    mode_d      = mode_q;
    limit_d     = limit_q;
    pos_d       = pos_q;
    queue_d     = queue_q;
    fill_d      = fill_q;
    refill_d    = refill_q;
    runb_d      = runb_q;
    sub_d       = sub_q;
    plen_d      = plen_q;
    poff_d      = poff_q;
    done_d      = done_q;
    byte_d      = byte_q;
    clr_d       = clr_q;
    pre_d       = pre_q;
    src_d       = src_q;
    src_ok_d    = src_ok_q;
    c1_d        = c1_q;
    c2_d        = c2_q;
    tog_d       = tog_q;
    val_d       = val_q;
    out_val_d   = out_val_q;
    out_done_d  = out_done_q;
    out_cnt_d   = out_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_ctl_o   = '0;
    mem_waddr_o = put_addr;
    mem_wdata_o = byte_q;
    mem_raddr_o = src_q[AW-1:0];
    cp_start    = 1'b0;
    cp_add      = '0;
    cp_len      = plen_q;
    in_ready    = (sq_q == SQ_IDLE) && !out_valid_q;

    unique case (sq_q)
      SQ_CLEAR: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = clr_q;
        mem_wdata_o     = (32'(clr_q) < PreambleBytes) ? clr_q[10:3] : 8'h00;
        clr_d           = clr_q + AW'(1);
        if (clr_q == AW'(StoreBytes - 1)) begin
          sq_d = SQ_IDLE;
        end
      end

      SQ_IDLE: begin
        if (in_valid_i && in_ready) begin
          byte_d = data_byte_i;
          val_d  = 8'h00;
          case (func_i)
            FUNC_START: begin
              mode_d   = decode_mode_i;
              limit_d  = lim_new;
              done_d   = 1'b0;
              plen_d   = '0;
              poff_d   = '0;
              queue_d  = '0;
              fill_d   = '0;
              refill_d = decode_mode_i[1] ? 3'd4 : 3'd0;
              runb_d   = '0;
              sub_d    = '0;
              ph_d     = PH_TOP;
              if (decode_mode_i == MODE_TWO) begin
                pos_d = '0;
                pre_d = '0;
                sq_d  = SQ_PRE;
              end else begin
                pos_d = skip_new;
                sq_d  = SQ_ADV;
              end
            end
            FUNC_BYTE: begin
              if (ph_q == PH_IDLE || ph_q == PH_DONE) begin
                sq_d = SQ_RESP;
              end else if (refill_q != 3'd0) begin
                queue_d  = queue_q | (32'(data_byte_i) << fill_q);
                fill_d   = fill_q + 6'd8;
                refill_d = refill_q - 3'd1;
                sq_d     = SQ_ADV;
              end else begin
                sq_d = SQ_FEED;
              end
            end
            FUNC_READ: begin
              if (32'(read_address_i) < IMAGE_BYTES) begin
                mem_ctl_o.rd_en = 1'b1;
                mem_raddr_o     = AW'(PreambleBytes) + AW'(read_address_i);
                sq_d            = SQ_RDWAIT;
              end else begin
                sq_d = SQ_RESP;
              end
            end
            default: sq_d = SQ_RESP;
          endcase
        end
      end

      SQ_RDWAIT: begin
        val_d = mem_rdata_i;
        sq_d  = SQ_RESP;
      end

      SQ_PRE: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = AW'(pre_q);
        mem_wdata_o     = pre_q[11:4];
        pre_d           = pre_q + 12'd1;
        if (pre_q == 12'hFFF) begin
          sq_d = SQ_ADV;
        end
      end

      SQ_FEED: begin
        sq_d = SQ_ADV;
        unique case (ph_q)
          PH_TAGBYTE: begin
            queue_d = 32'(byte_q);
            fill_d  = 6'd8;
            ph_d    = PH_TOP;
          end
          PH_LIT: begin
            mem_ctl_o.wr_en = pos_room;
            if (pos_room) pos_d = pos_q + PW'(1);
            ph_d = PH_TOP;
          end
          PH_NEAR_A: begin
            plen_d = 17'(byte_q[3:0]) + 17'd3;
            poff_d = 12'(byte_q[7:4]);
            ph_d   = PH_NEAR_B;
          end
          PH_NEAR_B: begin
            cp_start = 1'b1;
            cp_add   = 14'({byte_q, 4'h0}) + 14'(poff_q);
          end
          PH_SKIP2: begin
            pos_d = skip_to(pos_q, TW'(byte_q) + TW'(2), limit_q);
            ph_d  = PH_TOP;
          end
          PH_SKIP5: begin
            if (byte_q == 8'h00) begin
              done_d   = 1'b1;
              ph_d     = PH_DONE;
              refill_d = '0;
              sq_d     = SQ_RESP;
            end else if (byte_q != 8'hFF) begin
              pos_d = skip_to(pos_q, TW'(byte_q) + TW'(1), limit_q);
              ph_d  = PH_TOP;
            end else begin
              ph_d = PH_SKIPLO;
            end
          end
          PH_SKIPLO: begin
            plen_d = 17'(byte_q);
            ph_d   = PH_SKIPHI;
          end
          PH_SKIPHI: begin
            pos_d = skip_to(pos_q, TW'({byte_q, plen_q[7:0]}) + TW'(1), limit_q);
            ph_d  = PH_TOP;
          end
          PH_SHORT5: begin
            cp_start = 1'b1;
            cp_add   = 14'(PreambleBytes) - 14'(byte_q[7:2]) - 14'd1;
            cp_len   = 17'(byte_q[1:0]) + 17'd2;
          end
          PH_RUNLIT: begin
            mem_ctl_o.wr_en = pos_room;
            if (pos_room) pos_d = pos_q + PW'(1);
            plen_d = run_left;
            if (run_left == 17'd0) ph_d = PH_TOP;
          end
          PH_SKB: begin
            if (!byte_q[7]) begin
              pos_d = skip_to(pos_q, TW'(byte_q) + TW'(18), limit_q);
              ph_d  = PH_TOP;
            end else begin
              plen_d = 17'({byte_q[6:0], 8'h00});
              ph_d   = PH_SKC;
            end
          end
          PH_SKC: begin
            pos_d = skip_to(pos_q, TW'(plen_q) + TW'(byte_q) + TW'(146), limit_q);
            ph_d  = PH_TOP;
          end
          PH_T2B: begin
            if (sub_q != 2'd0 || offs <= 12'hF80) begin
              cp_start = 1'b1;
              cp_add   = 14'(offs);
              cp_len   = 17'(sub_q) + 17'd3;
            end else if (offs == 12'hFFF) begin
              done_d   = 1'b1;
              ph_d     = PH_DONE;
              refill_d = '0;
              sq_d     = SQ_RESP;
            end else begin
              src_d  = SW'(pos_q) + SW'(PreambleBytes) - SW'(offs[6:4]) - SW'(1);
              plen_d = 17'({offs[3:0], 1'b0}) + 17'd4;
              ph_d   = PH_TOP;
              sq_d   = SQ_PF1;
            end
          end
          PH_NEAR8: begin
            cp_start = 1'b1;
            cp_add   = 14'(PreambleBytes) - 14'(byte_q[6:0]) - 14'd1;
            cp_len   = byte_q[7] ? 17'd3 : 17'd2;
          end
          PH_FAR: begin
            if (mode_q == MODE_SIX) begin
              poff_d = {byte_q[3:0], 8'h00};
              if (byte_q[7:4] == 4'hF) begin
                ph_d = PH_FARLEN;
              end else begin
                plen_d = 17'(byte_q[7:4]) + 17'd6;
                ph_d   = PH_FAROFF;
              end
            end else if (byte_q[7:6] == 2'b11) begin
              plen_d = 17'(byte_q[5:0]) + 17'd8;
              ph_d   = PH_FWD4;
            end else if (!byte_q[7]) begin
              plen_d = 17'(byte_q[7:4]) + 17'd6;
              poff_d = {byte_q[3:0], 8'h00};
              ph_d   = PH_FAROFF;
            end else begin
              plen_d = 17'(byte_q[5:0]) + 17'd14;
              ph_d   = PH_FAR4;
            end
          end
          PH_FARLEN: begin
            plen_d = 17'(byte_q) + 17'd21;
            ph_d   = PH_FAROFF;
          end
          PH_FAROFF: begin
            cp_start = 1'b1;
            cp_add   = 14'(offs);
          end
          PH_FWDOFF: begin
            cp_start = 1'b1;
            cp_add   = 14'(PreambleBytes) + 14'(offs) + 14'd1;
          end
          default: sq_d = SQ_RESP;
        endcase
        if (cp_start) begin
          src_d  = (src_new > end_s) ? end_s : src_new;
          plen_d = cp_len;
          ph_d   = PH_TOP;
          sq_d   = SQ_CPRD;
        end
      end

      SQ_ADV: begin
        sq_d = SQ_RESP;
        if (ph_q == PH_TOP && !pos_room) begin
          done_d   = 1'b1;
          ph_d     = PH_DONE;
          refill_d = '0;
        end else if (ph_q == PH_TOP && !mode_q[1]) begin
          if (fill_q == 6'd0) begin
            ph_d = PH_TAGBYTE;
          end else begin
            queue_d = {24'h0, queue_q[5:0], 2'b00};
            fill_d  = fill_q - 6'd2;
            case (queue_q[7:6])
              2'd0: ph_d = PH_LIT;
              2'd1: ph_d = PH_NEAR_A;
              2'd2: ph_d = (mode_q == MODE_TWO) ? PH_SKIP2 : PH_SKIP5;
              default: begin
                if (mode_q == MODE_TWO) begin
                  done_d   = 1'b1;
                  ph_d     = PH_DONE;
                  refill_d = '0;
                end else begin
                  ph_d = PH_SHORT5;
                end
              end
            endcase
          end
        end else if (tk_n != 5'd0) begin
          if (refill_q != 3'd0) begin
            sq_d = SQ_RESP;
          end else if (fill_q <= 6'd16) begin
            refill_d = 3'd2;
          end else begin
            sq_d    = SQ_ADV;
            queue_d = tk_rest;
            fill_d  = fill_q - 6'(tk_n);
            unique case (ph_q)
              PH_TOP: begin
                case (tk_val[1:0])
                  2'd0:    ph_d = PH_T0;
                  2'd1:    ph_d = PH_T1;
                  2'd2:    ph_d = PH_T2;
                  default: ph_d = PH_FAR;
                endcase
              end
              PH_T0: begin
                if (tk_val[0]) begin
                  plen_d = 17'd2;
                  runb_d = '0;
                  ph_d   = PH_RUNBITS;
                end else begin
                  ph_d = PH_LIT;
                end
              end
              PH_RUNBITS: begin
                runb_d = tk_n;
                plen_d = plen_q + 17'(tk_val[15:0]);
                if (tk_val != tk_mask || tk_n >= 5'd16) ph_d = PH_RUNLIT;
              end
              PH_T1: ph_d = tk_val[0] ? PH_SKB : PH_T1S;
              PH_T1S: begin
                pos_d = skip_to(pos_q, TW'(tk_val[3:0]) + TW'(2), limit_q);
                ph_d  = PH_TOP;
              end
              PH_T2: begin
                sub_d = tk_val[1:0];
                ph_d  = (tk_val[1:0] != 2'd3) ? PH_T2O : PH_NEAR8;
              end
              PH_T2O: begin
                poff_d = {tk_val[3:0], 8'h00};
                ph_d   = PH_T2B;
              end
              PH_FAR4: begin
                poff_d = {tk_val[3:0], 8'h00};
                ph_d   = PH_FAROFF;
              end
              PH_FWD4: begin
                poff_d = {tk_val[3:0], 8'h00};
                ph_d   = PH_FWDOFF;
              end
              default: sq_d = SQ_RESP;
            endcase
          end
        end else if (ph_q != PH_IDLE && ph_q != PH_DONE && mode_q[1] && refill_q == 3'd0
                     && fill_q <= 6'd16) begin
          refill_d = 3'd2;
        end
      end

      SQ_CPRD: begin
        if (plen_q == 17'd0 || !pos_room) begin
          sq_d = SQ_ADV;
        end else begin
          src_ok_d        = src_q < end_s;
          mem_ctl_o.rd_en = src_q < end_s;
          if (src_q < end_s) src_d = src_p1;
          sq_d = SQ_CPWR;
        end
      end

      SQ_CPWR: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_wdata_o     = src_ok_q ? mem_rdata_i : 8'h00;
        pos_d           = pos_q + PW'(1);
        plen_d          = plen_q - 17'd1;
        sq_d            = SQ_CPRD;
      end

      SQ_PF1: begin
        if (!pos_room) begin
          sq_d = SQ_ADV;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          sq_d            = SQ_PF2;
        end
      end

      SQ_PF2: begin
        c1_d            = mem_rdata_i;
        mem_ctl_o.rd_en = 1'b1;
        mem_raddr_o     = src_p1[AW-1:0];
        sq_d            = SQ_PF3;
      end

      SQ_PF3: begin
        c2_d  = mem_rdata_i;
        tog_d = 1'b0;
        sq_d  = SQ_PFW;
      end

      SQ_PFW: begin
        if (plen_q == 17'd0 || !pos_room) begin
          sq_d = SQ_ADV;
        end else begin
          mem_ctl_o.wr_en = 1'b1;
          mem_wdata_o     = tog_q ? c2_q : c1_q;
          pos_d           = pos_q + PW'(1);
          plen_d          = plen_q - 17'd1;
          tog_d           = !tog_q;
        end
      end

      SQ_RESP: begin
        out_valid_d = 1'b1;
        out_val_d   = val_q;
        out_done_d  = done_q;
        out_cnt_d   = 17'(pos_q);
        sq_d        = SQ_IDLE;
      end

      default: sq_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q        <= SQ_CLEAR;
      ph_q        <= PH_IDLE;
      mode_q      <= MODE_SIX;
      limit_q     <= '0;
      pos_q       <= '0;
      queue_q     <= '0;
      fill_q      <= '0;
      refill_q    <= '0;
      runb_q      <= '0;
      sub_q       <= '0;
      plen_q      <= '0;
      poff_q      <= '0;
      done_q      <= 1'b0;
      clr_q       <= '0;
      pre_q       <= '0;
      src_ok_q    <= 1'b0;
      tog_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sq_q        <= sq_d;
      ph_q        <= ph_d;
      mode_q      <= mode_d;
      limit_q     <= limit_d;
      pos_q       <= pos_d;
      queue_q     <= queue_d;
      fill_q      <= fill_d;
      refill_q    <= refill_d;
      runb_q      <= runb_d;
      sub_q       <= sub_d;
      plen_q      <= plen_d;
      poff_q      <= poff_d;
      done_q      <= done_d;
      clr_q       <= clr_d;
      pre_q       <= pre_d;
      src_ok_q    <= src_ok_d;
      tog_q       <= tog_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    src_q      <= src_d;
    c1_q       <= c1_d;
    c2_q       <= c2_d;
    val_q      <= val_d;
    out_val_q  <= out_val_d;
    out_done_q <= out_done_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign in_ready_o    = in_ready;
  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_val_q;
  assign frame_done_o  = out_done_q;
  assign write_count_o = out_cnt_q;

endmodule

// File: rtl/lz_frame_delta_decompressor.sv
`timescale 1ns / 1ps
// Reset: control clears at once, then the frame store is initialized one byte per cycle
// over all 4096 + IMAGE_BYTES bytes (preamble pattern, image zero) with in_ready_o low.
// Path: an ignored request goes straight to SQ_RESP, a read passes SQ_RDWAIT, a start SQ_ADV
// (method two first writes the 4096-byte preamble), a refilling byte SQ_ADV, any other byte
// SQ_FEED then SQ_ADV, plus bit-field steps, copies (SQ_CPRD, SQ_CPWR) and fills (SQ_PFW).
// Flow: one request at a time; copies read then write each pixel, fills reuse two read bytes.

module lz_frame_delta_decompressor #(
  parameter int unsigned IMAGE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] read_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_value_o,
  output logic        frame_done_o,
  output logic [16:0] write_count_o
);
  import lzfd_pkg::*;

  localparam int unsigned StoreBytes = PreambleBytes + IMAGE_BYTES;
  localparam int unsigned AW = $clog2(StoreBytes);

  logic [16:0]   image_pixels_q;
  logic [23:0]   frame_skip_q;
  logic [1:0]    decode_mode_q;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_pixels_q <= 17'd64000;
      frame_skip_q   <= '0;
      decode_mode_q  <= MODE_SIX;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_PIXELS: image_pixels_q <= cfg_wdata_i[16:0];
        CFG_FRAME_SKIP:   frame_skip_q   <= cfg_wdata_i;
        CFG_DECODE_MODE:  decode_mode_q  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  lzfd_ctrl #(
    .IMAGE_BYTES(IMAGE_BYTES)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .image_pixels_i (image_pixels_q),
    .frame_skip_i   (frame_skip_q),
    .decode_mode_i  (decode_mode_q),
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .data_byte_i,
    .read_address_i,
    .out_valid_o,
    .out_ready_i,
    .read_value_o,
    .frame_done_o,
    .write_count_o,
    .mem_ctl_o      (mem_ctl),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  lzfd_store #(
    .Depth(StoreBytes),
    .AddrW(AW)
  ) u_store (
    .clk_i,
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: rtl/lzfd_checker.sv
`timescale 1ns / 1ps
`include "lz_frame_delta_decompressor_defines.svh"

module lzfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_index_i,
  input logic [23:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  func_i,
  input logic [7:0]  data_byte_i,
  input logic [15:0] read_address_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  read_value_o,
  input logic        frame_done_o,
  input logic [16:0] write_count_o
);

  `LZFD_ASSERT_SAME(a_ready_only_when_drained, in_ready_o, !out_valid_o, "ready with result held")

  `LZFD_ASSERT_NEXT(a_busy_after_request, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o, "not busy after request")

  `LZFD_ASSERT_NEXT(a_single_result, out_valid_o && out_ready_i, !out_valid_o, "result repeated")

  `LZFD_ASSERT_NEXT(a_result_held, out_valid_o && !out_ready_i, out_valid_o && $stable(read_value_o) && $stable(frame_done_o) && $stable(write_count_o), "stalled result changed")

endmodule

bind lz_frame_delta_decompressor lzfd_checker u_lzfd_checker (.*);
